// ----- hw/rtl/dcl_pkg.sv -----
// Shared constants for the DBSCAN cluster labeler: field widths, register
// indexes, reset values, command action codes and parameter defaults.
// No dependencies.
package dcl_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 12;

   localparam int EPS_W    = 25;
   localparam int MINP_W   = 11;
   localparam int OUT_W    = 11;
   localparam int RIDX_W   = 10;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_EPS_SQUARED = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POINTS  = CSR_IDX_W'(1);

   localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(400);
   localparam logic [MINP_W-1:0] MINP_RESET = MINP_W'(4);

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

endpackage

// ----- hw/rtl/dcl_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module dcl_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write on request, registered read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dcl_near_pipe.sv -----
// Three-stage squared-distance pipeline: flags a point as a neighbour of the
// reference point when its squared distance is below eps_squared. Uses dcl_pkg.
module dcl_near_pipe
   import dcl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] ref_x,
   input  logic [COORD_BITS-1:0] ref_y,
   input  logic [COORD_BITS-1:0] pt_x,
   input  logic [COORD_BITS-1:0] pt_y,
   input  logic [EPS_W-1:0]      eps_squared,
   output logic                  out_valid,
   output logic                  out_near,
   output logic                  busy
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 1;
   localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]       sqx_ff, sqy_ff;
   logic [SUM_W-1:0]      sum;
   logic                  near_ff, near_in;

   // absolute differences, sum of squares and compare against eps_squared
   always_comb begin
      dx_in = (ref_x > pt_x) ? ref_x - pt_x : pt_x - ref_x;
      dy_in = (ref_y > pt_y) ? ref_y - pt_y : pt_y - ref_y;
      sum     = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
      near_in = CMP_W'(sum) < CMP_W'(eps_squared);
   end

   // advance valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload stages: differences, squares, compare
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sqy_ff  <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      near_ff <= near_in;
   end

   assign out_valid = v3_ff;
   assign out_near  = near_ff;
   assign busy      = v1_ff | v2_ff | v3_ff;

endmodule

// ----- hw/rtl/dbscan_cluster_labeler.sv -----
// Top level of the DBSCAN cluster labeler: command port, run sequencer and
// the coordinate, label and stack memories. Uses dcl_pkg, dcl_ram, dcl_near_pipe.
//
// A load without last_point and a label read are taken one per cycle while
// busy is low; each gives its result on the cycle after acceptance, marked by
// rsp_valid for one cycle, and the receiver cannot stall. A load with
// last_point keeps busy high for the whole run and its result comes when the
// run ends. The run first clears the labels of the n points loaded. The outer
// pass then steps over the points, skips labelled ones and gives each
// unlabelled point a core test that streams every point through the distance
// pipeline; a core point opens a cluster and a neighbour scan that labels each
// unlabelled neighbour and tests it in turn; a core neighbour saves the current
// frame on the stack and starts its own scan, and the frame is popped when that
// scan ends. During a core test the single read port of the coordinate memory feeds the pipeline one point a cycle.
module dbscan_cluster_labeler
   import dcl_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  logic [COORD_BITS-1:0] req_coord_x,
   input  logic [COORD_BITS-1:0] req_coord_y,
   input  logic                  req_last_point,
   input  logic [RIDX_W-1:0]     req_read_index,
   output logic                  rsp_valid,
   output logic [OUT_W-1:0]      rsp_label,
   output logic [OUT_W-1:0]      rsp_cluster_total,
   output logic [OUT_W-1:0]      rsp_point_total,
   output logic                  rsp_overflow,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [EPS_W-1:0]      csr_data
);

   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int CRD_W  = 2 * COORD_BITS;
   localparam int STK_W  = IDX_W + CNT_W;
   localparam int MP_W   = (CNT_W > MINP_W) ? CNT_W : MINP_W;
   localparam int RC_W   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CLEAR     = 4'd1;
   localparam logic [3:0] S_OUT_LBL   = 4'd2;
   localparam logic [3:0] S_OUT_CHK   = 4'd3;
   localparam logic [3:0] S_CORE_REF  = 4'd4;
   localparam logic [3:0] S_CORE_LAT  = 4'd5;
   localparam logic [3:0] S_CORE_SCAN = 4'd6;
   localparam logic [3:0] S_CORE_DONE = 4'd7;
   localparam logic [3:0] S_NB_NEXT   = 4'd8;
   localparam logic [3:0] S_NB_WAIT   = 4'd9;
   localparam logic [3:0] S_NB_PIPE   = 4'd10;
   localparam logic [3:0] S_POP_WAIT  = 4'd11;
   localparam logic [3:0] S_POP_REF   = 4'd12;

   logic [3:0]            state_ff, state_in;
   logic [CNT_W-1:0]      loaded_ff, loaded_in;
   logic [CNT_W-1:0]      run_n_ff, run_n_in;
   logic [CNT_W-1:0]      cluster_ff, cluster_in;
   logic [CNT_W-1:0]      outer_ff, outer_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      sd_ff, sd_in;
   logic [CNT_W-1:0]      tscan_ff, tscan_in;
   logic [IDX_W-1:0]      tp_ff, tp_in;
   logic [IDX_W-1:0]      cand_ff, cand_in;
   logic                  ret_nb_ff, ret_nb_in;
   logic                  issue_ff, issue_in;
   logic                  ovf_hold_ff, ovf_hold_in;
   logic [COORD_BITS-1:0] core_x_ff, core_x_in, core_y_ff, core_y_in;
   logic [COORD_BITS-1:0] top_x_ff, top_x_in, top_y_ff, top_y_in;
   logic [EPS_W-1:0]      eps_ff;
   logic [MINP_W-1:0]     minp_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_lsel_ff, rsp_lsel_in;
   logic [OUT_W-1:0]      rsp_cluster_ff, rsp_cluster_in;
   logic [OUT_W-1:0]      rsp_point_ff, rsp_point_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  coord_we;
   logic [IDX_W-1:0]      coord_waddr, coord_raddr;
   logic [CRD_W-1:0]      coord_wdata, coord_rdata;
   logic                  lbl_we;
   logic [IDX_W-1:0]      lbl_waddr, lbl_raddr;
   logic [CNT_W-1:0]      lbl_wdata, lbl_rdata;
   logic                  stk_we;
   logic [IDX_W-1:0]      stk_waddr, stk_raddr;
   logic [STK_W-1:0]      stk_wdata, stk_rdata;

   logic                  pipe_in_valid, pipe_sel_top;
   logic                  near_valid, near, pipe_busy;
   logic                  accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // point coordinates, packed x over y
   dcl_ram #(.DEPTH(MAX_POINTS), .WIDTH(CRD_W)) u_coord (
      .clock(clock), .wr_en(coord_we), .wr_addr(coord_waddr), .wr_data(coord_wdata),
      .rd_addr(coord_raddr), .rd_data(coord_rdata)
   );

   // cluster labels
   dcl_ram #(.DEPTH(MAX_POINTS), .WIDTH(CNT_W)) u_label (
      .clock(clock), .wr_en(lbl_we), .wr_addr(lbl_waddr), .wr_data(lbl_wdata),
      .rd_addr(lbl_raddr), .rd_data(lbl_rdata)
   );

   // saved search frames below the top of stack
   dcl_ram #(.DEPTH(MAX_POINTS), .WIDTH(STK_W)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   assign pipe_sel_top  = (state_ff == S_NB_WAIT);
   assign pipe_in_valid = issue_ff || (pipe_sel_top && (lbl_rdata == '0));

   dcl_near_pipe #(.COORD_BITS(COORD_BITS)) u_near (
      .clock(clock), .reset(reset), .in_valid(pipe_in_valid),
      .ref_x(pipe_sel_top ? top_x_ff : core_x_ff),
      .ref_y(pipe_sel_top ? top_y_ff : core_y_ff),
      .pt_x(coord_rdata[CRD_W-1:COORD_BITS]), .pt_y(coord_rdata[COORD_BITS-1:0]),
      .eps_squared(eps_ff), .out_valid(near_valid), .out_near(near), .busy(pipe_busy)
   );

   // sequence commands and the clustering run
   always_comb begin
      logic [CNT_W-1:0] load_next;
      logic             ovf;
      logic             is_core;
      load_next = loaded_ff;
      ovf       = 1'b0;
      is_core   = MP_W'(cnt_ff) >= MP_W'(minp_ff);

      state_in    = state_ff;
      loaded_in   = loaded_ff;
      run_n_in    = run_n_ff;
      cluster_in  = cluster_ff;
      outer_in    = outer_ff;
      k_in        = k_ff;
      cnt_in      = cnt_ff;
      sd_in       = sd_ff;
      tscan_in    = tscan_ff;
      tp_in       = tp_ff;
      cand_in     = cand_ff;
      ret_nb_in   = ret_nb_ff;
      issue_in    = 1'b0;
      ovf_hold_in = ovf_hold_ff;
      core_x_in   = core_x_ff;
      core_y_in   = core_y_ff;
      top_x_in    = top_x_ff;
      top_y_in    = top_y_ff;

      rsp_valid_in   = 1'b0;
      rsp_lsel_in    = 1'b0;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_point_in   = rsp_point_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      coord_we    = 1'b0;
      coord_waddr = loaded_ff[IDX_W-1:0];
      coord_wdata = {req_coord_x, req_coord_y};
      coord_raddr = '0;
      lbl_we      = 1'b0;
      lbl_waddr   = '0;
      lbl_wdata   = '0;
      lbl_raddr   = '0;
      stk_we      = 1'b0;
      stk_waddr   = '0;
      stk_wdata   = '0;
      stk_raddr   = '0;

      case (state_ff)
         S_IDLE: begin
            lbl_raddr = IDX_W'(req_read_index);
            if (accept) begin
               if (req_action == ACT_LOAD) begin
                  if (loaded_ff < CNT_W'(MAX_POINTS)) begin
                     coord_we  = 1'b1;
                     load_next = loaded_ff + 1'b1;
                  end else begin
                     ovf = 1'b1;
                  end
                  loaded_in = load_next;
                  if (req_last_point) begin
                     run_n_in    = load_next;
                     cluster_in  = '0;
                     k_in        = '0;
                     ovf_hold_in = ovf;
                     state_in    = S_CLEAR;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_cluster_in = OUT_W'(cluster_ff);
                     rsp_point_in   = OUT_W'(load_next);
                     rsp_ovf_in     = ovf;
                  end
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_lsel_in    = RC_W'(req_read_index) < RC_W'(run_n_ff);
                  rsp_cluster_in = OUT_W'(cluster_ff);
                  rsp_point_in   = OUT_W'(loaded_ff);
                  rsp_ovf_in     = 1'b0;
               end
            end
         end
         S_CLEAR: begin
            if (k_ff < loaded_ff) begin
               lbl_we    = 1'b1;
               lbl_waddr = k_ff[IDX_W-1:0];
               k_in      = k_ff + 1'b1;
            end else begin
               outer_in = '0;
               state_in = S_OUT_LBL;
            end
         end
         S_OUT_LBL: begin
            if (outer_ff < loaded_ff) begin
               lbl_raddr = outer_ff[IDX_W-1:0];
               state_in  = S_OUT_CHK;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_cluster_in = OUT_W'(cluster_ff);
               rsp_point_in   = OUT_W'(loaded_ff);
               rsp_ovf_in     = ovf_hold_ff;
               state_in       = S_IDLE;
            end
         end
         S_OUT_CHK: begin
            if (lbl_rdata != '0) begin
               outer_in = outer_ff + 1'b1;
               state_in = S_OUT_LBL;
            end else begin
               cand_in   = outer_ff[IDX_W-1:0];
               ret_nb_in = 1'b0;
               state_in  = S_CORE_REF;
            end
         end
         S_CORE_REF: begin
            coord_raddr = cand_ff;
            state_in    = S_CORE_LAT;
         end
         S_CORE_LAT: begin
            core_x_in = coord_rdata[CRD_W-1:COORD_BITS];
            core_y_in = coord_rdata[COORD_BITS-1:0];
            k_in      = '0;
            cnt_in    = '0;
            state_in  = S_CORE_SCAN;
         end
         S_CORE_SCAN: begin
            // stream every point through the distance pipeline and count
            if (k_ff < loaded_ff) begin
               coord_raddr = k_ff[IDX_W-1:0];
               issue_in    = 1'b1;
               k_in        = k_ff + 1'b1;
            end
            if (near_valid && near) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (k_ff >= loaded_ff && !issue_ff && !pipe_busy) begin
               state_in = S_CORE_DONE;
            end
         end
         S_CORE_DONE: begin
            if (is_core) begin
               if (!ret_nb_ff) begin
                  cluster_in = cluster_ff + 1'b1;
                  lbl_we     = 1'b1;
                  lbl_waddr  = cand_ff;
                  lbl_wdata  = cluster_ff + 1'b1;
                  sd_in      = CNT_W'(1);
               end else begin
                  // save the current frame with its resume position
                  stk_we    = 1'b1;
                  stk_waddr = IDX_W'(sd_ff - 1'b1);
                  stk_wdata = {tp_ff, tscan_ff + 1'b1};
                  sd_in     = sd_ff + 1'b1;
               end
               tp_in    = cand_ff;
               tscan_in = '0;
               top_x_in = core_x_ff;
               top_y_in = core_y_ff;
               state_in = S_NB_NEXT;
            end else if (!ret_nb_ff) begin
               outer_in = outer_ff + 1'b1;
               state_in = S_OUT_LBL;
            end else begin
               tscan_in = tscan_ff + 1'b1;
               state_in = S_NB_NEXT;
            end
         end
         S_NB_NEXT: begin
            if (tscan_ff < loaded_ff) begin
               lbl_raddr   = tscan_ff[IDX_W-1:0];
               coord_raddr = tscan_ff[IDX_W-1:0];
               state_in    = S_NB_WAIT;
            end else begin
               // pop the finished frame
               sd_in = sd_ff - 1'b1;
               if (sd_ff == CNT_W'(1)) begin
                  outer_in = outer_ff + 1'b1;
                  state_in = S_OUT_LBL;
               end else begin
                  stk_raddr = IDX_W'(sd_ff - CNT_W'(2));
                  state_in  = S_POP_WAIT;
               end
            end
         end
         S_NB_WAIT: begin
            if (lbl_rdata != '0) begin
               tscan_in = tscan_ff + 1'b1;
               state_in = S_NB_NEXT;
            end else begin
               state_in = S_NB_PIPE;
            end
         end
         S_NB_PIPE: begin
            if (near_valid) begin
               if (near) begin
                  lbl_we    = 1'b1;
                  lbl_waddr = tscan_ff[IDX_W-1:0];
                  lbl_wdata = cluster_ff;
                  cand_in   = tscan_ff[IDX_W-1:0];
                  ret_nb_in = 1'b1;
                  state_in  = S_CORE_REF;
               end else begin
                  tscan_in = tscan_ff + 1'b1;
                  state_in = S_NB_NEXT;
               end
            end
         end
         S_POP_WAIT: begin
            tp_in       = stk_rdata[STK_W-1:CNT_W];
            tscan_in    = stk_rdata[CNT_W-1:0];
            coord_raddr = stk_rdata[STK_W-1:CNT_W];
            state_in    = S_POP_REF;
         end
         S_POP_REF: begin
            top_x_in = coord_rdata[CRD_W-1:COORD_BITS];
            top_y_in = coord_rdata[COORD_BITS-1:0];
            state_in = S_NB_NEXT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         run_n_ff     <= '0;
         cluster_ff   <= '0;
         outer_ff     <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         sd_ff        <= '0;
         tscan_ff     <= '0;
         ret_nb_ff    <= 1'b0;
         issue_ff     <= 1'b0;
         ovf_hold_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_lsel_ff  <= 1'b0;
         eps_ff       <= EPS_RESET;
         minp_ff      <= MINP_RESET;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         run_n_ff     <= run_n_in;
         cluster_ff   <= cluster_in;
         outer_ff     <= outer_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         sd_ff        <= sd_in;
         tscan_ff     <= tscan_in;
         ret_nb_ff    <= ret_nb_in;
         issue_ff     <= issue_in;
         ovf_hold_ff  <= ovf_hold_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_lsel_ff  <= rsp_lsel_in;
         // take register transfers
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EPS_SQUARED: eps_ff  <= csr_data;
               CSR_MIN_POINTS:  minp_ff <= csr_data[MINP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tp_ff          <= tp_in;
      cand_ff        <= cand_in;
      core_x_ff      <= core_x_in;
      core_y_ff      <= core_y_in;
      top_x_ff       <= top_x_in;
      top_y_ff       <= top_y_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_point_ff   <= rsp_point_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_label         = rsp_lsel_ff ? OUT_W'(lbl_rdata) : '0;
   assign rsp_cluster_total = rsp_cluster_ff;
   assign rsp_point_total   = rsp_point_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule
